>>> rtl/tss_pkg.sv
// Shared constants, register indexes and controller command type for the TDMA slot scheduler.
package tss_pkg;

   localparam int TIME_WIDTH = 32;
   localparam int STEP_W     = $clog2(TIME_WIDTH);
   localparam int ADDR_W     = 4;
   localparam int SLOT_W     = 16;
   localparam int TICK_W     = 15;
   localparam int TOA_W      = 16;
   localparam int GUARD_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_ADDR  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_MS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_MS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOA_MS     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_GUARD = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RS_ENABLE  = 3'd6;

   localparam logic [ADDR_W-1:0]  NODE_ADDR_RST  = 4'd1;
   localparam logic [ADDR_W-1:0]  NODE_COUNT_RST = 4'd7;
   localparam logic [SLOT_W-1:0]  SLOT_MS_RST    = 16'd1000;
   localparam logic [TICK_W-1:0]  TICK_MS_RST    = 15'd250;
   localparam logic [TOA_W-1:0]   TOA_MS_RST     = 16'd100;
   localparam logic [GUARD_W-1:0] SYNC_GUARD_RST = 32'd6300;

   // at most one command per cycle from controller to datapath
   typedef struct packed {
      logic load;     // latch the input beat
      logic anchor;   // apply a sync if the guard allows
      logic prep;     // load the divider with the elapsed time
      logic step;     // one quotient bit
      logic commit;   // update slot state and load the result register
   } cmd_type;

endpackage

>>> rtl/tss_datapath.sv
// Datapath: config registers, timing state, bit-serial slot divider and result register.
module tss_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  tss_pkg::cmd_type                cmd,
   input  logic                            csr_wr_en,
   input  logic [tss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tss_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                            req_func,
   input  logic [tss_pkg::TIME_WIDTH-1:0]  req_now_ms,
   input  logic [tss_pkg::ADDR_W-1:0]      req_sender_addr,
   input  logic                            req_queue_nonempty,
   output logic                            rsp_transmit_now,
   output logic                            rsp_round_start,
   output logic [tss_pkg::ADDR_W-1:0]      rsp_slot_owner,
   output logic [tss_pkg::TIME_WIDTH-1:0]  rsp_abs_slot,
   output logic                            rsp_in_tx_window,
   output logic                            rsp_sync_applied
);

   localparam int TW = tss_pkg::TIME_WIDTH;
   localparam int AW = tss_pkg::ADDR_W;
   localparam int SW = tss_pkg::SLOT_W;

   // configuration
   logic [AW-1:0]                node_addr_ff, node_addr_in;
   logic [AW-1:0]                node_count_ff, node_count_in;
   logic [SW-1:0]                slot_ms_ff, slot_ms_in;
   logic [tss_pkg::TICK_W-1:0]   tick_ms_ff, tick_ms_in;
   logic [tss_pkg::TOA_W-1:0]    toa_ms_ff, toa_ms_in;
   logic [tss_pkg::GUARD_W-1:0]  guard_ff, guard_in;
   logic                         rs_enable_ff, rs_enable_in;

   // timing state
   logic [TW-1:0] anchor_ff, anchor_in;
   logic [TW-1:0] last_tx_ff, last_tx_in;
   logic [TW-1:0] last_notify_ff, last_notify_in;
   logic [TW-1:0] last_sync_ff, last_sync_in;
   logic          sync_seen_ff, sync_seen_in;

   // latched beat and working registers
   logic          func_ff, func_in;
   logic [TW-1:0] now_ff, now_in;
   logic [AW-1:0] sender_ff, sender_in;
   logic          queued_ff, queued_in;
   logic          applied_ff, applied_in;
   logic [TW-1:0] quo_ff, quo_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [AW-1:0] own_ff, own_in;

   // result register
   logic          tx_ff, tx_in;
   logic          rs_ff, rs_in;
   logic [AW-1:0] owner_ff, owner_in;
   logic [TW-1:0] slot_ff, slot_in;
   logic          win_ff, win_in;
   logic          sapp_ff, sapp_in;

   logic [SW-1:0]     len;
   logic [AW-1:0]     cnt;
   logic [TW-1:0]     since_sync;
   logic              guard_ok;
   logic [AW+SW-1:0]  prod;
   logic [TW-1:0]     offset;
   logic [SW:0]       rem_shift;
   logic              rem_ge;
   logic [AW:0]       own_shift;
   logic [AW-1:0]     owner;
   logic              win;
   logic              owned;

   always_comb begin
      len        = (slot_ms_ff == '0) ? SW'(1) : slot_ms_ff;
      cnt        = (node_count_ff == '0) ? AW'(1) : node_count_ff;
      since_sync = now_ff - last_sync_ff;
      guard_ok   = !sync_seen_ff || (since_sync > TW'(guard_ff));
      prod       = sender_ff * slot_ms_ff;
      // (sender - 1) * slot + tick + toa, wrapping
      offset     = TW'(prod) - TW'(slot_ms_ff) + TW'(tick_ms_ff) + TW'(toa_ms_ff);
      rem_shift  = {rem_ff, quo_ff[TW-1]};
      rem_ge     = rem_shift >= {1'b0, len};
      own_shift  = {own_ff, rem_ge};
      owner      = own_ff + AW'(1);
      win        = ({1'b0, rem_ff} >= (SW+1)'(tick_ms_ff))
                   && ({1'b0, rem_ff} < {1'b0, tick_ms_ff, 1'b0});
      owned      = (owner == node_addr_ff);
   end

   always_comb begin
      node_addr_in   = node_addr_ff;
      node_count_in  = node_count_ff;
      slot_ms_in     = slot_ms_ff;
      tick_ms_in     = tick_ms_ff;
      toa_ms_in      = toa_ms_ff;
      guard_in       = guard_ff;
      rs_enable_in   = rs_enable_ff;
      anchor_in      = anchor_ff;
      last_tx_in     = last_tx_ff;
      last_notify_in = last_notify_ff;
      last_sync_in   = last_sync_ff;
      sync_seen_in   = sync_seen_ff;
      func_in        = func_ff;
      now_in         = now_ff;
      sender_in      = sender_ff;
      queued_in      = queued_ff;
      applied_in     = applied_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      own_in         = own_ff;
      tx_in          = tx_ff;
      rs_in          = rs_ff;
      owner_in       = owner_ff;
      slot_in        = slot_ff;
      win_in         = win_ff;
      sapp_in        = sapp_ff;

      if (csr_wr_en) begin
         case (csr_index)
            tss_pkg::CSR_NODE_ADDR:  node_addr_in  = csr_wr_data[AW-1:0];
            tss_pkg::CSR_NODE_COUNT: node_count_in = csr_wr_data[AW-1:0];
            tss_pkg::CSR_SLOT_MS:    slot_ms_in    = csr_wr_data[SW-1:0];
            tss_pkg::CSR_TICK_MS:    tick_ms_in    = csr_wr_data[tss_pkg::TICK_W-1:0];
            tss_pkg::CSR_TOA_MS:     toa_ms_in     = csr_wr_data[tss_pkg::TOA_W-1:0];
            tss_pkg::CSR_SYNC_GUARD: guard_in      = csr_wr_data[tss_pkg::GUARD_W-1:0];
            tss_pkg::CSR_RS_ENABLE:  rs_enable_in  = csr_wr_data[0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         func_in    = req_func;
         now_in     = req_now_ms;
         sender_in  = req_sender_addr;
         queued_in  = req_queue_nonempty;
         applied_in = 1'b0;
      end

      if (cmd.anchor && func_ff && guard_ok) begin
         anchor_in    = now_ff - offset;
         last_tx_in   = '1;
         last_sync_in = now_ff;
         sync_seen_in = 1'b1;
         applied_in   = 1'b1;
      end

      if (cmd.prep) begin
         quo_in = now_ff - anchor_ff;
         rem_in = '0;
         own_in = '0;
      end

      // restoring divide by the slot length; slot mod count tracked alongside
      if (cmd.step) begin
         quo_in = {quo_ff[TW-2:0], rem_ge};
         rem_in = rem_ge ? SW'(rem_shift - {1'b0, len}) : rem_shift[SW-1:0];
         own_in = (own_shift >= {1'b0, cnt}) ? AW'(own_shift - {1'b0, cnt})
                                             : own_shift[AW-1:0];
      end

      if (cmd.commit) begin
         tx_in    = 1'b0;
         rs_in    = 1'b0;
         owner_in = owner;
         slot_in  = quo_ff;
         win_in   = win;
         sapp_in  = applied_ff;
         if (!func_ff && owned) begin
            if (rs_enable_ff && (quo_ff != last_notify_ff)) begin
               rs_in          = 1'b1;
               last_notify_in = quo_ff;
            end
            if (win && (quo_ff != last_tx_ff) && queued_ff) begin
               tx_in      = 1'b1;
               last_tx_in = quo_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_addr_ff   <= tss_pkg::NODE_ADDR_RST;
         node_count_ff  <= tss_pkg::NODE_COUNT_RST;
         slot_ms_ff     <= tss_pkg::SLOT_MS_RST;
         tick_ms_ff     <= tss_pkg::TICK_MS_RST;
         toa_ms_ff      <= tss_pkg::TOA_MS_RST;
         guard_ff       <= tss_pkg::SYNC_GUARD_RST;
         rs_enable_ff   <= 1'b0;
         anchor_ff      <= '0;
         last_tx_ff     <= '1;
         last_notify_ff <= '1;
         last_sync_ff   <= '0;
         sync_seen_ff   <= 1'b0;
      end else begin
         node_addr_ff   <= node_addr_in;
         node_count_ff  <= node_count_in;
         slot_ms_ff     <= slot_ms_in;
         tick_ms_ff     <= tick_ms_in;
         toa_ms_ff      <= toa_ms_in;
         guard_ff       <= guard_in;
         rs_enable_ff   <= rs_enable_in;
         anchor_ff      <= anchor_in;
         last_tx_ff     <= last_tx_in;
         last_notify_ff <= last_notify_in;
         last_sync_ff   <= last_sync_in;
         sync_seen_ff   <= sync_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      now_ff     <= now_in;
      sender_ff  <= sender_in;
      queued_ff  <= queued_in;
      applied_ff <= applied_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      own_ff     <= own_in;
      tx_ff      <= tx_in;
      rs_ff      <= rs_in;
      owner_ff   <= owner_in;
      slot_ff    <= slot_in;
      win_ff     <= win_in;
      sapp_ff    <= sapp_in;
   end

   assign rsp_transmit_now = tx_ff;
   assign rsp_round_start  = rs_ff;
   assign rsp_slot_owner   = owner_ff;
   assign rsp_abs_slot     = slot_ff;
   assign rsp_in_tx_window = win_ff;
   assign rsp_sync_applied = sapp_ff;

endmodule

>>> rtl/tss_ctrl.sv
// Controller: sequences accept, re-anchor, divide and result handoff.
module tss_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tss_pkg::cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ANCHOR = 5'b00010,
      ST_PREP   = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type                    state_ff, state_in;
   logic [tss_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         out_free;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_ANCHOR;
            end
         end
         ST_ANCHOR: begin
            cmd.anchor = 1'b1;
            state_in   = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            step_in  = step_ff + tss_pkg::STEP_W'(1);
            if (step_ff == tss_pkg::STEP_W'(tss_pkg::TIME_WIDTH - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the result register is free
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/tdma_slot_scheduler.sv
// Top level of the TDMA slot scheduler: controller plus datapath.
//
// Usage:
//   The req channel carries one beat per poll (req_func 0) or heard sync
//   (req_func 1); a beat moves at a clock edge where req_valid is high and
//   req_stall is low. Every beat yields exactly one rsp beat, taken at an
//   edge where rsp_valid is high and rsp_stall is low.
//   After the edge that accepts its request, a beat passes a re-anchor step
//   (no-op for polls), a divider load step, the one-bit-per-cycle slot
//   divider and a commit step that writes the result register.
//   Only one beat is in flight: a new request is accepted only after the
//   32-step divide of the elapsed time by the slot length and the commit.
//   The result sits in an output register, so a new request is accepted
//   while the previous result still waits; if rsp_stall stays high the
//   finished beat holds in the commit step and req_stall stays high.
//   Reset (synchronous, active high) loads the register defaults, clears
//   the anchor and sync history and marks no slot as served yet.
//   The csr port writes a register whenever csr_wr_en is high; write only
//   while no beat is in flight.
module tdma_slot_scheduler (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [tss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tss_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_func,
   input  logic [tss_pkg::TIME_WIDTH-1:0]  req_now_ms,
   input  logic [tss_pkg::ADDR_W-1:0]      req_sender_addr,
   input  logic                            req_queue_nonempty,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_transmit_now,
   output logic                            rsp_round_start,
   output logic [tss_pkg::ADDR_W-1:0]      rsp_slot_owner,
   output logic [tss_pkg::TIME_WIDTH-1:0]  rsp_abs_slot,
   output logic                            rsp_in_tx_window,
   output logic                            rsp_sync_applied
);

   tss_pkg::cmd_type cmd;

   // sequencing and handshakes
   tss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // registers, timing state, divider and result register
   tss_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .req_func           (req_func),
      .req_now_ms         (req_now_ms),
      .req_sender_addr    (req_sender_addr),
      .req_queue_nonempty (req_queue_nonempty),
      .rsp_transmit_now   (rsp_transmit_now),
      .rsp_round_start    (rsp_round_start),
      .rsp_slot_owner     (rsp_slot_owner),
      .rsp_abs_slot       (rsp_abs_slot),
      .rsp_in_tx_window   (rsp_in_tx_window),
      .rsp_sync_applied   (rsp_sync_applied)
   );

endmodule
